// File: design/assert_macros.svh
// assertion macros shared by the design files
// each macro checks on the rising edge of clock and is disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/bsoc_pkg.sv
// constants, breakpoint tables and types for the battery charge estimator
// no dependencies; imported by battery_soc_from_voltage

package bsoc_pkg;

   // field widths
   localparam int MV_W      = 13;
   localparam int TEMP_W    = 12;
   localparam int PCT_W     = 7;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLD_LIMIT = 1'b0,
      CSR_HOT_LIMIT  = 1'b1
   } csr_index_type;

   localparam logic signed [CSR_W-1:0] COLD_LIMIT_RST = 12'sd100;
   localparam logic signed [CSR_W-1:0] HOT_LIMIT_RST  = 12'sd350;

   // breakpoint table, highest voltage first
   localparam int TABLE_POINTS = 11;
   localparam int LAST = (TABLE_POINTS - 1 > 15) ? 15 :
                         ((TABLE_POINTS - 1 < 1) ? 1 : TABLE_POINTS - 1);

   localparam logic [MV_W-1:0] BP_MV [16] = '{
      13'd2640, 13'd2560, 13'd2500, 13'd2460, 13'd2420, 13'd2380, 13'd2340, 13'd2300,
      13'd2240, 13'd2160, 13'd2000, 13'd2000, 13'd2000, 13'd2000, 13'd2000, 13'd2000
   };
   localparam logic [PCT_W-1:0] BP_PC [16] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30,
      7'd20, 7'd10, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
   };

   // level in 1/256 percent
   localparam int LVL_FRAC = 8;
   localparam int LVL_ONE  = 1 << LVL_FRAC;
   localparam int LVL_W    = 15;
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(100 * LVL_ONE);
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   function automatic int bits_for(int n);
      int b;
      b = 1;
      while (b < 31 && (1 << b) <= n) b = b + 1;
      return b;
   endfunction

   // widest voltage span of any segment
   function automatic int max_span();
      int m;
      int s;
      m = 0;
      for (int i = 0; i < LAST; i++) begin
         s = int'(BP_MV[i]) - int'(BP_MV[i+1]);
         if (s > m) m = s;
      end
      return m;
   endfunction

   // largest level step of any segment
   function automatic int max_step();
      int m;
      int s;
      m = 0;
      for (int i = 0; i < LAST; i++) begin
         s = (int'(BP_PC[i]) - int'(BP_PC[i+1])) * LVL_ONE;
         if (s > m) m = s;
      end
      return m;
   endfunction

   localparam int MAX_SPAN = max_span();
   localparam int MAX_STEP = max_step();
   localparam int SEG_W    = bits_for(LAST - 1);
   localparam int DV_W     = bits_for(MAX_SPAN);
   localparam int STEP_W   = bits_for(MAX_STEP);
   localparam int NUM_W    = bits_for(MAX_SPAN * MAX_STEP);
   // reciprocal shift exact for every numerator below 2**NUM_W
   localparam int REC_K    = NUM_W + DV_W;
   localparam int REC_W    = REC_K + 1;

   // temperature correction: cold dt*256/20 = dt*64/5, hot dt*256/50 = dt*128/25
   localparam int DT_W     = TEMP_W;
   localparam int COLD_SH  = 6;
   localparam int COLD_DIV = 5;
   localparam int HOT_SH   = 7;
   localparam int HOT_DIV  = 25;
   localparam int TNUM_W   = DT_W + HOT_SH;
   localparam int T_K      = 24;
   localparam int TM_W     = 22;
   localparam logic [TM_W-1:0] COLD_MUL =
      TM_W'(((64'd1 << T_K) + 64'(COLD_DIV) - 64'd1) / 64'(COLD_DIV));
   localparam logic [TM_W-1:0] HOT_MUL =
      TM_W'(((64'd1 << T_K) + 64'(HOT_DIV) - 64'd1) / 64'(HOT_DIV));

   localparam int CORR_W = 16;
   localparam logic [CORR_W-1:0] COLD_BASE = CORR_W'(5 * LVL_ONE);
   localparam logic [CORR_W-1:0] HOT_BASE  = CORR_W'(3 * LVL_ONE);
   localparam int SOC_W = 18;

   typedef enum logic [1:0] {
      CORR_NONE,
      CORR_COLD,
      CORR_HOT
   } corr_mode_type;

endpackage

// File: design/battery_soc_from_voltage.sv
// battery state of charge estimator: breakpoint interpolation plus temperature correction
// depends on bsoc_pkg and assert_macros.svh
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   pack_voltage_mv, temperature_decideg
//  rsp_      out        rsp_valid/rsp_ready   charge_percent
//  csr_      in         csr_we                csr_index, csr_wdata
//
// four register stages: segment search, level numerator and temperature reciprocal
// multiply, level reciprocal multiply, correction and clamp into the output register.
// one request per cycle is taken while the output is not stalled.
// each stage holds only while its successor is full and stalled, so bubbles close up
// and the input keeps accepting while a result waits at the output until the stages fill.
// synchronous reset clears the stage valid bits and loads the limit registers.

`include "assert_macros.svh"

module battery_soc_from_voltage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bsoc_pkg::MV_W-1:0]           req_pack_voltage_mv,
   input  logic signed [bsoc_pkg::TEMP_W-1:0]  req_temperature_decideg,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bsoc_pkg::PCT_W-1:0]          rsp_charge_percent,
   input  logic                                csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsoc_pkg::CSR_W-1:0]          csr_wdata
);

   import bsoc_pkg::*;

   // configuration registers
   logic signed [CSR_W-1:0] cold_limit_ff;
   logic signed [CSR_W-1:0] hot_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_limit_ff <= COLD_LIMIT_RST;
         hot_limit_ff  <= HOT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLD_LIMIT: cold_limit_ff <= csr_wdata;
            CSR_HOT_LIMIT:  hot_limit_ff  <= csr_wdata;
         endcase
      end
   end

   // per-segment constant tables
   logic [MV_W-1:0]  seg_mv_lo [LAST];
   logic [LVL_W-1:0] seg_lo    [LAST];
   logic [STEP_W-1:0] seg_step [LAST];
   logic [REC_W-1:0] seg_rec   [LAST];

   for (genvar gi = 0; gi < LAST; gi++) begin : g_seg
      localparam int SPAN = int'(BP_MV[gi]) - int'(BP_MV[gi+1]);
      localparam int DIV  = (SPAN > 0) ? SPAN : 1;
      localparam logic [REC_W-1:0] REC =
         REC_W'(((64'd1 << REC_K) + 64'(DIV) - 64'd1) / 64'(DIV));
      assign seg_mv_lo[gi] = BP_MV[gi+1];
      assign seg_lo[gi]    = LVL_W'(int'(BP_PC[gi+1]) * LVL_ONE);
      // a flat segment yields its lower level
      assign seg_step[gi]  = (SPAN > 0) ?
                             STEP_W'((int'(BP_PC[gi]) - int'(BP_PC[gi+1])) * LVL_ONE) : '0;
      assign seg_rec[gi]   = REC;
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign rsp_valid = s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: segment search and temperature comparison
   logic [LAST-1:0]   seg_hit;
   logic [SEG_W-1:0]  s1_seg_in, s1_seg_ff;
   logic [MV_W-1:0]   dv_full;
   logic [DV_W-1:0]   s1_dv_in, s1_dv_ff;
   logic [LVL_W-1:0]  s1_lo_in, s1_lo_ff;
   logic              at_top, at_bottom;
   logic signed [TEMP_W:0] cold_diff, hot_diff;
   corr_mode_type     s1_mode_in, s1_mode_ff;
   logic [DT_W-1:0]   s1_dt_in, s1_dt_ff;

   always_comb begin
      for (int i = 0; i < LAST; i++) begin
         seg_hit[i] = (req_pack_voltage_mv <= BP_MV[i]) &&
                      (req_pack_voltage_mv >= BP_MV[i+1]);
      end
      // first matching segment wins
      s1_seg_in = '0;
      for (int i = LAST - 1; i >= 0; i--) begin
         if (seg_hit[i]) s1_seg_in = SEG_W'(i);
      end
      at_top    = req_pack_voltage_mv >= BP_MV[0];
      at_bottom = req_pack_voltage_mv <= BP_MV[LAST];
      dv_full   = req_pack_voltage_mv - seg_mv_lo[s1_seg_in];
      priority if (at_top) begin
         s1_lo_in = LVL_W'(int'(BP_PC[0]) * LVL_ONE);
         s1_dv_in = '0;
      end else if (at_bottom) begin
         s1_lo_in = LVL_W'(int'(BP_PC[LAST]) * LVL_ONE);
         s1_dv_in = '0;
      end else begin
         s1_lo_in = seg_lo[s1_seg_in];
         s1_dv_in = dv_full[DV_W-1:0];
      end

      // cold check takes precedence over hot
      cold_diff = (TEMP_W+1)'(cold_limit_ff) - (TEMP_W+1)'(req_temperature_decideg);
      hot_diff  = (TEMP_W+1)'(req_temperature_decideg) - (TEMP_W+1)'(hot_limit_ff);
      priority if (req_temperature_decideg < cold_limit_ff) begin
         s1_mode_in = CORR_COLD;
         s1_dt_in   = cold_diff[DT_W-1:0];
      end else if (req_temperature_decideg > hot_limit_ff) begin
         s1_mode_in = CORR_HOT;
         s1_dt_in   = hot_diff[DT_W-1:0];
      end else begin
         s1_mode_in = CORR_NONE;
         s1_dt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_seg_ff  <= s1_seg_in;
         s1_dv_ff   <= s1_dv_in;
         s1_lo_ff   <= s1_lo_in;
         s1_mode_ff <= s1_mode_in;
         s1_dt_ff   <= s1_dt_in;
      end
   end

   // stage 2: level numerator and temperature correction by reciprocal
   logic [DV_W+STEP_W-1:0]   num_full;
   logic [NUM_W-1:0]         s2_num_in, s2_num_ff;
   logic [SEG_W-1:0]         s2_seg_ff;
   logic [LVL_W-1:0]         s2_lo_ff;
   logic [TNUM_W-1:0]        tnum;
   logic [TM_W-1:0]          tmul;
   logic [CORR_W-1:0]        tbase;
   logic [TNUM_W+TM_W-1:0]   tprod;
   logic [CORR_W-1:0]        s2_corr_in, s2_corr_ff;
   corr_mode_type            s2_mode_ff;

   always_comb begin
      num_full  = s1_dv_ff * seg_step[s1_seg_ff];
      s2_num_in = num_full[NUM_W-1:0];
      if (s1_mode_ff == CORR_COLD) begin
         tnum  = TNUM_W'(s1_dt_ff) << COLD_SH;
         tmul  = COLD_MUL;
         tbase = COLD_BASE;
      end else begin
         tnum  = TNUM_W'(s1_dt_ff) << HOT_SH;
         tmul  = HOT_MUL;
         tbase = HOT_BASE;
      end
      tprod = tnum * tmul;
      s2_corr_in = (s1_mode_ff == CORR_NONE) ? '0 : tbase + tprod[T_K +: CORR_W];
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_num_ff  <= s2_num_in;
         s2_seg_ff  <= s1_seg_ff;
         s2_lo_ff   <= s1_lo_ff;
         s2_corr_ff <= s2_corr_in;
         s2_mode_ff <= s1_mode_ff;
      end
   end

   // stage 3: divide by the segment span and add the lower level
   logic [NUM_W+REC_W-1:0] lprod;
   logic [LVL_W-1:0]       s3_level_in, s3_level_ff;
   logic [CORR_W-1:0]      s3_corr_ff;
   corr_mode_type          s3_mode_ff;

   always_comb begin
      lprod       = s2_num_ff * seg_rec[s2_seg_ff];
      s3_level_in = s2_lo_ff + lprod[REC_K +: LVL_W];
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_level_ff <= s3_level_in;
         s3_corr_ff  <= s2_corr_ff;
         s3_mode_ff  <= s2_mode_ff;
      end
   end

   // stage 4: apply correction, clamp, round half up
   logic signed [SOC_W-1:0] soc;
   logic [LVL_W-1:0]        soc_clamped;
   logic [LVL_W:0]          soc_round;
   logic [PCT_W-1:0]        s4_pct_in, s4_pct_ff;

   always_comb begin
      unique case (s3_mode_ff)
         CORR_COLD: soc = SOC_W'(s3_level_ff) - SOC_W'(s3_corr_ff);
         CORR_HOT:  soc = SOC_W'(s3_level_ff) + SOC_W'(s3_corr_ff);
         default:   soc = SOC_W'(s3_level_ff);
      endcase
      priority if (soc < 0) begin
         soc_clamped = '0;
      end else if (soc > SOC_W'(LVL_MAX)) begin
         soc_clamped = LVL_MAX;
      end else begin
         soc_clamped = soc[LVL_W-1:0];
      end
      soc_round = (LVL_W+1)'(soc_clamped) + (LVL_W+1)'(LVL_ONE / 2);
      s4_pct_in = soc_round[LVL_FRAC +: PCT_W];
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_pct_ff <= s4_pct_in;
      end
   end

   assign rsp_charge_percent = s4_pct_ff;

   // checks
   `ASSERT_IMPL(a_pct_range, rsp_valid, rsp_charge_percent <= PCT_MAX)
   `ASSERT_IMPL(a_level_range, s3_valid_ff, s3_level_ff <= LVL_MAX)
   `ASSERT_IMPL(a_no_corr, s2_valid_ff && s2_mode_ff == CORR_NONE, s2_corr_ff == '0)
   `ASSERT_NEXT(a_advance, s3_valid_ff && s4_ready, rsp_valid)

endmodule

// File: bench/bsoc_checker.sv
// checker for the battery charge estimator: watches the request, result and register ports
// predicts each charge level from its own copy of the limits; depends on bsoc_pkg
`timescale 1ns / 1ps

module bsoc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [bsoc_pkg::MV_W-1:0]           req_pack_voltage_mv,
   input  logic signed [bsoc_pkg::TEMP_W-1:0]  req_temperature_decideg,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [bsoc_pkg::PCT_W-1:0]          rsp_charge_percent,
   input  logic                                csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsoc_pkg::CSR_W-1:0]          csr_wdata,
   output int                                  failure_count,
   output int                                  pending_count
);
   import bsoc_pkg::*;

   // discharge curve of a two-cell pack, highest voltage first
   localparam int KNEE_COUNT = 11;
   localparam int KNEE_MV [KNEE_COUNT] =
      '{2640, 2560, 2500, 2460, 2420, 2380, 2340, 2300, 2240, 2160, 2000};
   localparam int KNEE_PC [KNEE_COUNT] =
      '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0};

   logic signed [TEMP_W-1:0] cold_limit_copy;
   logic signed [TEMP_W-1:0] hot_limit_copy;
   logic [PCT_W-1:0]         expected_percent_q [$];

   // charge in whole percent for one reading, working in 1/256 percent
   function automatic logic [PCT_W-1:0] charge_from_reading(
      input logic [MV_W-1:0] mv,
      input logic signed [TEMP_W-1:0] temp,
      input logic signed [TEMP_W-1:0] cold,
      input logic signed [TEMP_W-1:0] hot
   );
      int v;
      int t;
      int level;
      bit found;
      v = int'(mv);
      t = int'(temp);
      level = 0;
      found = 1'b0;
      if (v >= KNEE_MV[0]) begin
         level = KNEE_PC[0] * 256;
      end else if (v <= KNEE_MV[KNEE_COUNT-1]) begin
         level = KNEE_PC[KNEE_COUNT-1] * 256;
      end else begin
         for (int seg = 0; seg < KNEE_COUNT - 1; seg++) begin
            if (!found && v <= KNEE_MV[seg] && v >= KNEE_MV[seg+1]) begin
               found = 1'b1;
               level = KNEE_PC[seg+1] * 256 +
                       ((v - KNEE_MV[seg+1]) * (KNEE_PC[seg] - KNEE_PC[seg+1]) * 256) /
                       (KNEE_MV[seg] - KNEE_MV[seg+1]);
            end
         end
      end
      // cold penalty wins when both limits are crossed
      if (t < int'(cold))
         level = level - (5 * 256 + ((int'(cold) - t) * 256) / 20);
      else if (t > int'(hot))
         level = level + (3 * 256 + ((t - int'(hot)) * 256) / 50);
      if (level < 0) level = 0;
      if (level > 100 * 256) level = 100 * 256;
      return PCT_W'((level + 128) >> 8);
   endfunction

   // predict on each request, compare on each result, track register writes
   always @(posedge clock) begin
      logic [PCT_W-1:0] oldest;
      if (reset) begin
         cold_limit_copy = COLD_LIMIT_RST;
         hot_limit_copy  = HOT_LIMIT_RST;
         expected_percent_q.delete();
         failure_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_percent_q.push_back(charge_from_reading(req_pack_voltage_mv,
               req_temperature_decideg, cold_limit_copy, hot_limit_copy));
         if (rsp_valid && rsp_ready) begin
            if (expected_percent_q.size() == 0) begin
               $error("charge_percent with no request pending: actual %0d",
                      rsp_charge_percent);
               failure_count <= failure_count + 1;
            end else begin
               oldest = expected_percent_q.pop_front();
               if (rsp_charge_percent !== oldest) begin
                  $error("charge_percent mismatch: expected %0d, actual %0d",
                         oldest, rsp_charge_percent);
                  failure_count <= failure_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_COLD_LIMIT: cold_limit_copy = csr_wdata;
               CSR_HOT_LIMIT:  hot_limit_copy  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count <= expected_percent_q.size();
   end

endmodule

// File: bench/tb.sv
// testbench top for battery_soc_from_voltage: clock, reset, stimulus and verdict
// depends on bsoc_pkg, the block itself and bsoc_checker
`timescale 1ns / 1ps

module tb;
   import bsoc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASE_COUNT  = 6;
   localparam int SETTLE_LEN   = 8;
   localparam int TEMP_LO      = -550;
   localparam int TEMP_HI      = 1250;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [MV_W-1:0]            req_pack_voltage_mv = '0;
   logic signed [TEMP_W-1:0]   req_temperature_decideg = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [PCT_W-1:0]           rsp_charge_percent;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_COLD_LIMIT;
   logic [CSR_W-1:0]           csr_wdata = '0;
   int                         failure_count;
   int                         pending_count;
   int                         cycle_count = 0;

   // receiver stall pattern state
   int                         stall_mode = 0;
   int                         stall_left = 0;
   int                         stall_phase = 0;

   // limit pairs for each phase; the first phase keeps the reset values
   int cold_plan [PHASE_COUNT];
   int hot_plan  [PHASE_COUNT];

   always #1 clock = ~clock;

   battery_soc_from_voltage dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_pack_voltage_mv     (req_pack_voltage_mv),
      .req_temperature_decideg (req_temperature_decideg),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_charge_percent      (rsp_charge_percent),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   bsoc_checker scoreboard (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_pack_voltage_mv     (req_pack_voltage_mv),
      .req_temperature_decideg (req_temperature_decideg),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_charge_percent      (rsp_charge_percent),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .failure_count           (failure_count),
      .pending_count           (pending_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("battery_soc_from_voltage verification failed");
         $finish;
      end
   end

   // receiver: switches between always ready, random stalls and a periodic stall
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_left  = $urandom_range(20, 120);
         stall_phase = 0;
      end
      stall_left  = stall_left - 1;
      stall_phase = stall_phase + 1;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ready <= ((stall_phase % 7) < 4);
         default: rsp_ready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   // present one reading and hold it until taken; valid stays high afterwards
   task automatic send_reading(input int mv, input int temp);
      req_valid               <= 1'b1;
      req_pack_voltage_mv     <= MV_W'(mv);
      req_temperature_decideg <= TEMP_W'(temp);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and let every outstanding result come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   // load both limits on consecutive cycles
   task automatic write_limits(input int cold, input int hot);
      csr_we    <= 1'b1;
      csr_index <= CSR_COLD_LIMIT;
      csr_wdata <= CSR_W'(cold);
      @(posedge clock);
      csr_index <= CSR_HOT_LIMIT;
      csr_wdata <= CSR_W'(hot);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic int clamp_temp(input int t);
      if (t < TEMP_LO) return TEMP_LO;
      if (t > TEMP_HI) return TEMP_HI;
      return t;
   endfunction

   // voltages mostly on the discharge curve, some anywhere, some on or next to a knee
   function automatic int pick_voltage();
      int knees [11] = '{2640, 2560, 2500, 2460, 2420, 2380, 2340, 2300, 2240, 2160, 2000};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(1990, 2650);
         6, 7:             return $urandom_range(0, 8191);
         default:          return knees[$urandom_range(0, 10)] + $urandom_range(0, 2) - 1;
      endcase
   endfunction

   // temperatures spread over the range with extra weight around each limit
   function automatic int pick_temperature(input int cold, input int hot);
      case ($urandom_range(0, 5))
         0:       return clamp_temp(cold + $urandom_range(0, 8) - 4);
         1:       return clamp_temp(hot + $urandom_range(0, 8) - 4);
         default: return $urandom_range(0, TEMP_HI - TEMP_LO) + TEMP_LO;
      endcase
   endfunction

   initial begin
      int burst_left;
      int gap;
      int calm;
      cold_plan = '{100, -550, 1250, 1250, -550, 0};
      hot_plan  = '{350, 1250, -550, 1250, -550, 0};
      cold_plan[PHASE_COUNT-1] = $urandom_range(0, TEMP_HI - TEMP_LO) + TEMP_LO;
      hot_plan[PHASE_COUNT-1]  = $urandom_range(0, TEMP_HI - TEMP_LO) + TEMP_LO;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: curve ends and knees, limit edges, saturation both ways
      send_reading(0, -550);
      send_reading(8191, 1250);
      send_reading(2640, 250);
      send_reading(2641, 250);
      send_reading(2639, 250);
      send_reading(2000, 250);
      send_reading(2001, 250);
      send_reading(1999, 250);
      send_reading(2560, 250);
      send_reading(2530, 250);
      send_reading(2200, 250);
      send_reading(2300, 100);
      send_reading(2300, 99);
      send_reading(2300, 350);
      send_reading(2300, 351);
      send_reading(2640, 1250);
      send_reading(2000, -550);
      send_reading(2400, -550);
      send_reading(2400, 1250);
      send_reading(5000, 0);
      send_reading(2450, -1);
      drain_results();

      // random phases, one limit setting each
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) write_limits(cold_plan[phase], hot_plan[phase]);
         calm = (phase == 2);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_reading(pick_voltage(), pick_temperature(cold_plan[phase], hot_plan[phase]));
            // sender holds off mid-phase until the pipeline is empty
            if (phase == 3 && n == PHASE_ITEMS / 2) begin
               drain_results();
            end else if (!calm) begin
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  gap = $urandom_range(1, 8);
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
                  burst_left = $urandom_range(1, 24);
               end
            end
         end
         drain_results();
      end

      if (failure_count == 0 && pending_count == 0)
         $display("battery_soc_from_voltage verification clean");
      else
         $display("battery_soc_from_voltage verification failed");
      $finish;
   end

endmodule

// File: battery_soc_from_voltage.f
+incdir+design
design/bsoc_pkg.sv
design/battery_soc_from_voltage.sv
bench/bsoc_checker.sv
bench/tb.sv
